FILE: design/best_fit_heap_allocator_defines.svh
// Assertion macros for the best-fit heap allocator.
`ifndef BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BFHA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("best-fit heap allocator: implication check failed");
`define BFHA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("best-fit heap allocator: next-cycle check failed");
`else
`define BFHA_ASSERT_IMP(lbl, ante, cons)
`define BFHA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: design/bfha_pkg.sv
// Types, constants and command encodings shared by the heap allocator modules.
`timescale 1ns / 1ps
`default_nettype none

package bfha_pkg;

	localparam int HEAP_WORDS = 1024;
	localparam int HEAP_AW    = $clog2(HEAP_WORDS);

	localparam logic [31:0] END_MARK = 32'h0000_0001;
	localparam logic [31:0] PREV_BIT = 32'h0000_0002;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_NOFIT = 2'd2,
		ST_WALK  = 2'd3
	} status_e;

	typedef struct packed {
		op_e         op;
		logic [15:0] request_bytes;
		logic [9:0]  word_index;
		logic [31:0] write_word;
	} req_t;

	typedef struct packed {
		status_e     status;
		logic [11:0] payload_offset;
		logic [31:0] read_data;
	} rsp_t;

	typedef enum logic [2:0] {
		RD_IDX,
		RD_ZERO,
		RD_WIDX,
		RD_WALK,
		RD_EXACT
	} rd_sel_e;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_REQ,
		WR_EXACT,
		WR_PREV,
		WR_BEST,
		WR_REM
	} wr_sel_e;

	typedef enum logic [1:0] {
		POS_NONE,
		POS_IDX,
		POS_BEST
	} pos_sel_e;

	typedef struct packed {
		logic     capture;
		logic     start_walk;
		logic     walk_adv;
		rd_sel_e  rd_sel;
		wr_sel_e  wr_sel;
		logic     set_status;
		status_e  status;
		pos_sel_e pos_sel;
		logic     take_rdata;
		logic     load_rsp;
	} dp_cmd_t;

	typedef struct packed {
		op_e  op;
		logic req_zero;
		logic hdr_end;
		logic hdr_zero;
		logic hdr_exact;
		logic walk_off;
		logic exact_nxt_ok;
		logic best_vld;
		logic split_nxt_ok;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: design/bfha_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module bfha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/bfha_ctrl.sv
// Controller state machine: sequences decode, heap walk, update and response.
`timescale 1ns / 1ps
`default_nettype none

module bfha_ctrl import bfha_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_stall,
	output logic         rsp_valid,
	input  wire logic    rsp_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_WALK,
		S_EXRD,
		S_SPLIT,
		S_REM,
		S_RDW,
		S_FIN
	} state_e;

	state_e state_q;
	state_e state_d;
	logic   rsp_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.rd_sel     = RD_IDX;
		cmd.wr_sel     = WR_NONE;
		cmd.status     = ST_OK;
		cmd.pos_sel    = POS_NONE;
		state_d        = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_START;
				end
			end
			S_START: begin
				unique case (sts.op)
					OP_ALLOC: begin
						if (sts.req_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_ZERO;
							state_d        = S_FIN;
						end else begin
							cmd.start_walk = 1'b1;
							cmd.rd_sel     = RD_ZERO;
							state_d        = S_WALK;
						end
					end
					OP_WRITE: begin
						cmd.wr_sel = WR_REQ;
						state_d    = S_FIN;
					end
					OP_READ: begin
						cmd.rd_sel = RD_WIDX;
						state_d    = S_RDW;
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_RDW: begin
				cmd.take_rdata = 1'b1;
				state_d        = S_FIN;
			end
			S_WALK: begin
				if (sts.hdr_end) begin
					if (sts.best_vld) begin
						state_d = S_SPLIT;
					end else begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_NOFIT;
						state_d        = S_FIN;
					end
				end else if (sts.hdr_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_WALK;
					state_d        = S_FIN;
				end else if (sts.hdr_exact) begin
					cmd.wr_sel  = WR_EXACT;
					cmd.pos_sel = POS_IDX;
					if (sts.exact_nxt_ok) begin
						cmd.rd_sel = RD_EXACT;
						state_d    = S_EXRD;
					end else begin
						state_d = S_FIN;
					end
				end else if (sts.walk_off) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_WALK;
					state_d        = S_FIN;
				end else begin
					cmd.walk_adv = 1'b1;
					cmd.rd_sel   = RD_WALK;
				end
			end
			S_EXRD: begin
				if (!sts.hdr_end) begin
					cmd.wr_sel = WR_PREV;
				end
				state_d = S_FIN;
			end
			S_SPLIT: begin
				cmd.wr_sel  = WR_BEST;
				cmd.pos_sel = POS_BEST;
				state_d     = sts.split_nxt_ok ? S_REM : S_FIN;
			end
			S_REM: begin
				cmd.wr_sel = WR_REM;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.load_rsp = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

FILE: design/bfha_dp.sv
// Datapath: heap memory, walk registers, best-fit tracking and response register.
`timescale 1ns / 1ps
`default_nettype none

module bfha_dp import bfha_pkg::*; (
	input  wire logic    clk,
	input  wire req_t    req_data,
	input  wire dp_cmd_t cmd,
	output dp_sts_t      sts,
	output rsp_t         rsp_data
);

	op_e                op_q;
	logic               req_zero_q;
	logic [16:0]        need_q;
	logic [9:0]         widx_q;
	logic [31:0]        wval_q;
	logic [HEAP_AW-1:0] idx_q;
	logic               best_vld_q;
	logic [HEAP_AW-1:0] best_idx_q;
	logic [29:0]        best_w_q;
	logic               best_prev_q;
	status_e            res_status_q;
	logic [HEAP_AW-1:0] res_pos_q;
	logic               res_pos_vld_q;
	logic [31:0]        res_rdata_q;
	rsp_t               rsp_q;

	logic [16:0]        need_sum;
	logic [31:0]        hdr;
	logic [29:0]        bsz_w;
	logic [14:0]        need_w;
	logic               hdr_free;
	logic               fits;
	logic               better;
	logic [30:0]        nxt_walk;
	logic [15:0]        exact_nxt;
	logic [15:0]        split_nxt;
	logic               widx_ok;
	logic               we;
	logic [HEAP_AW-1:0] waddr;
	logic [31:0]        wdata;
	logic [HEAP_AW-1:0] raddr;

	bfha_ram #(
		.WIDTH(32),
		.DEPTH(HEAP_WORDS)
	) u_heap (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(hdr)
	);

	assign need_sum  = 17'(req_data.request_bytes) + 17'd11;
	assign bsz_w     = hdr[31:2];
	assign need_w    = need_q[16:2];
	assign hdr_free  = !hdr[0];
	assign fits      = hdr_free && (bsz_w > 30'(need_w));
	assign better    = fits && (!best_vld_q || (bsz_w < best_w_q));
	assign nxt_walk  = 31'(idx_q) + 31'(bsz_w);
	assign exact_nxt = 16'(idx_q) + 16'(need_w);
	assign split_nxt = 16'(best_idx_q) + 16'(need_w);
	assign widx_ok   = 32'(widx_q) < 32'(HEAP_WORDS);

	always_comb begin
		sts              = '0;
		sts.op           = op_q;
		sts.req_zero     = req_zero_q;
		sts.hdr_end      = (hdr == END_MARK);
		sts.hdr_zero     = (bsz_w == '0);
		sts.hdr_exact    = hdr_free && (bsz_w == 30'(need_w));
		sts.walk_off     = (nxt_walk >= 31'(HEAP_WORDS));
		sts.exact_nxt_ok = (exact_nxt < 16'(HEAP_WORDS));
		sts.best_vld     = best_vld_q;
		sts.split_nxt_ok = (split_nxt < 16'(HEAP_WORDS));
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO:  raddr = '0;
			RD_WIDX:  raddr = HEAP_AW'(widx_q);
			RD_WALK:  raddr = nxt_walk[HEAP_AW-1:0];
			RD_EXACT: raddr = exact_nxt[HEAP_AW-1:0];
			default:  raddr = idx_q;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = '0;
		case (cmd.wr_sel)
			WR_REQ: begin
				we    = widx_ok;
				waddr = HEAP_AW'(widx_q);
				wdata = wval_q;
			end
			WR_EXACT: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = 32'({need_w, hdr[1], 1'b1});
			end
			WR_PREV: begin
				we    = 1'b1;
				waddr = exact_nxt[HEAP_AW-1:0];
				wdata = hdr | PREV_BIT;
			end
			WR_BEST: begin
				we    = 1'b1;
				waddr = best_idx_q;
				wdata = 32'({need_w, best_prev_q, 1'b1});
			end
			WR_REM: begin
				we    = 1'b1;
				waddr = split_nxt[HEAP_AW-1:0];
				wdata = {best_w_q - 30'(need_w), 2'b00} | PREV_BIT;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q          <= req_data.op;
			req_zero_q    <= (req_data.request_bytes == '0);
			need_q        <= {need_sum[16:3], 3'b000};
			widx_q        <= req_data.word_index;
			wval_q        <= req_data.write_word;
			res_status_q  <= ST_OK;
			res_pos_vld_q <= 1'b0;
			res_rdata_q   <= '0;
		end
		if (cmd.start_walk) begin
			idx_q      <= '0;
			best_vld_q <= 1'b0;
		end
		if (cmd.walk_adv) begin
			idx_q <= nxt_walk[HEAP_AW-1:0];
			if (better) begin
				best_vld_q  <= 1'b1;
				best_idx_q  <= idx_q;
				best_w_q    <= bsz_w;
				best_prev_q <= hdr[1];
			end
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status;
		end
		case (cmd.pos_sel)
			POS_IDX: begin
				res_pos_q     <= idx_q;
				res_pos_vld_q <= 1'b1;
			end
			POS_BEST: begin
				res_pos_q     <= best_idx_q;
				res_pos_vld_q <= 1'b1;
			end
			default: begin
			end
		endcase
		if (cmd.take_rdata) begin
			res_rdata_q <= widx_ok ? hdr : '0;
		end
		if (cmd.load_rsp) begin
			rsp_q.status         <= res_status_q;
			rsp_q.payload_offset <= res_pos_vld_q ? (12'({res_pos_q, 2'b00}) + 12'd4) : '0;
			rsp_q.read_data      <= res_rdata_q;
		end
	end

	assign rsp_data = rsp_q;

endmodule

`default_nettype wire

FILE: design/best_fit_heap_allocator.sv
// Top level of the best-fit heap allocator: controller, datapath and checks.
//
// Requests enter on req_valid/req_stall with a req_t payload and each yields
// exactly one response on rsp_valid/rsp_stall with an rsp_t payload.
// Op allocate walks the block headers in the 1024-word heap RAM at one header
// per cycle, takes the first exact fit or splits the smallest larger free block.
// Op write stores a heap word, op read returns one, the unused op answers zero.
// An allocate walk visits at most HEAP_WORDS headers via the RAM's one read port.
// One request is in flight at a time; req_stall is low only when the
// controller is idle. The response register lets the next request be accepted
// while a finished response waits; the new request stalls at its end until
// that response is taken. Reset clears the controller and response valid only;
// the heap contents stay undefined until written, so no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none
`include "best_fit_heap_allocator_defines.svh"

module best_fit_heap_allocator import bfha_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req_data,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	bfha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfha_dp u_dp (
		.clk     (clk),
		.req_data(req_data),
		.cmd     (cmd),
		.sts     (sts),
		.rsp_data(rsp_data)
	);

	`BFHA_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
	`BFHA_ASSERT_IMP(a_offset_only_ok, rsp_valid && rsp_data.status != ST_OK, rsp_data.payload_offset == '0)
	`BFHA_ASSERT_IMP(a_read_no_offset, rsp_valid && rsp_data.read_data != '0, rsp_data.payload_offset == '0 && rsp_data.status == ST_OK)

endmodule

`default_nettype wire

FILE: tb/tb_best_fit_heap_allocator.sv
// Self-checking testbench for the best-fit heap allocator with a scoreboard that mirrors the heap.
`timescale 1ns / 1ps

module tb_best_fit_heap_allocator;
	import bfha_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned BLOCK_SIZES [7] = '{8, 16, 24, 32, 48, 64, 128};
	localparam int unsigned PHASE_IDLE [4]  = '{0, 87, 0, 32};
	localparam int unsigned PHASE_STALL [4] = '{0, 0, 87, 32};

	class alloc_tracker;
		logic [31:0] mem [HEAP_WORDS];
		bit          written [HEAP_WORDS];
		rsp_t        answers_due [$];
		int          errors = 0;

		function status_e carve(input int unsigned req, output int unsigned at);
			int unsigned need, idx, bsz, best_idx, best_sz, nxt;
			logic [31:0] hdr;
			bit have_best;
			at = 0;
			have_best = 1'b0;
			best_idx = 0;
			best_sz = 0;
			if (req == 0)
				return ST_ZERO;
			need = (req + 11) & ~32'd7;
			idx = 0;
			while (1) begin
				if (idx >= HEAP_WORDS)
					return ST_WALK;
				hdr = mem[idx];
				if (hdr == END_MARK)
					break;
				bsz = hdr & ~32'd3;
				if (bsz == 0)
					return ST_WALK;
				if (!hdr[0]) begin
					if (bsz == need) begin
						mem[idx] = need | (hdr & PREV_BIT) | 32'd1;
						nxt = idx + need / 4;
						if (nxt < HEAP_WORDS && mem[nxt] != END_MARK)
							mem[nxt] = mem[nxt] | PREV_BIT;
						at = idx;
						return ST_OK;
					end
					if (bsz > need && (!have_best || bsz < best_sz)) begin
						have_best = 1'b1;
						best_idx = idx;
						best_sz = bsz;
					end
				end
				idx += bsz / 4;
			end
			if (!have_best)
				return ST_NOFIT;
			hdr = mem[best_idx];
			mem[best_idx] = need | (hdr & PREV_BIT) | 32'd1;
			nxt = best_idx + need / 4;
			if (nxt < HEAP_WORDS) begin
				mem[nxt] = ((best_sz - need) & ~32'd3) | PREV_BIT;
				written[nxt] = 1'b1;
			end
			at = best_idx;
			return ST_OK;
		endfunction

		// True when an allocation of req bytes touches only words already written.
		function bit walk_is_safe(input int unsigned req);
			int unsigned need, idx, bsz, nxt;
			logic [31:0] hdr;
			if (req == 0)
				return 1'b1;
			need = (req + 11) & ~32'd7;
			idx = 0;
			while (idx < HEAP_WORDS) begin
				if (!written[idx])
					return 1'b0;
				hdr = mem[idx];
				bsz = hdr & ~32'd3;
				if (hdr == END_MARK || bsz == 0)
					return 1'b1;
				if (!hdr[0] && bsz == need) begin
					nxt = idx + need / 4;
					return nxt >= HEAP_WORDS || written[nxt];
				end
				idx += bsz / 4;
			end
			return 1'b1;
		endfunction

		function rsp_t answer_for(input req_t r);
			rsp_t o;
			int unsigned at;
			o = '0;
			case (r.op)
				OP_ALLOC: begin
					o.status = carve(r.request_bytes, at);
					if (o.status == ST_OK)
						o.payload_offset = 12'(at * 4 + 4);
				end
				OP_WRITE: begin
					mem[r.word_index] = r.write_word;
					written[r.word_index] = 1'b1;
				end
				OP_READ: o.read_data = mem[r.word_index];
				default: ;
			endcase
			return o;
		endfunction

		function void note_request(input req_t r);
			answers_due.push_back(answer_for(r));
		endfunction

		function void check_response(input rsp_t got);
			rsp_t want;
			if (answers_due.size() == 0) begin
				$display("%0t: response %h with no request pending", $time, got);
				errors++;
				return;
			end
			want = answers_due.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d got %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.payload_offset !== want.payload_offset) begin
				$display("%0t: payload_offset expected %h got %h", $time,
					want.payload_offset, got.payload_offset);
				errors++;
			end
			if (got.read_data !== want.read_data) begin
				$display("%0t: read_data expected %h got %h", $time, want.read_data,
					got.read_data);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;

	alloc_tracker sb = new();
	int unsigned  cycles = 0;
	int unsigned  sent = 0;
	int unsigned  idle_pct = 0;
	int unsigned  stall_pct = 0;
	int unsigned  holds_asked = 0;

	best_fit_heap_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles <= CYCLE_LIMIT)
			@(posedge clk) cycles++;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned holds_done, hold_left;
		holds_done = 0;
		hold_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_asked != holds_done) begin
				holds_done = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp_data);
	end

	function automatic req_t mk_write(input int unsigned idx, input logic [31:0] word);
		req_t r;
		r = '0;
		r.op = OP_WRITE;
		r.word_index = 10'(idx);
		r.write_word = word;
		return r;
	endfunction

	function automatic req_t mk_read(input int unsigned idx);
		req_t r;
		r = '0;
		r.op = OP_READ;
		r.word_index = 10'(idx);
		return r;
	endfunction

	function automatic req_t mk_alloc(input int unsigned bytes);
		req_t r;
		r = '0;
		r.op = OP_ALLOC;
		r.request_bytes = 16'(bytes);
		return r;
	endfunction

	task automatic send(input req_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.answers_due.size() != 0)
			@(posedge clk);
	endtask

	// Lay out a block list from word 0, ending in the end mark or a free block to the heap's end.
	task automatic build_heap();
		int unsigned at, bsz, nblk, kind;
		logic [31:0] hdr;
		bit prev_busy, busy;
		kind = $urandom_range(0, 9);
		nblk = (kind == 0) ? $urandom_range(60, 200) : $urandom_range(3, 24);
		at = 0;
		prev_busy = 1'b1;
		for (int b = 0; b < nblk; b++) begin
			if (kind == 0)
				bsz = 8;
			else if ($urandom_range(0, 4) == 0)
				bsz = 4 * $urandom_range(2, 40);
			else
				bsz = BLOCK_SIZES[$urandom_range(0, 6)];
			if (at + bsz / 4 >= HEAP_WORDS)
				break;
			busy = ($urandom_range(0, 2) == 0);
			hdr = bsz | (prev_busy ? PREV_BIT : 32'd0) | 32'(busy);
			if ($urandom_range(0, 19) == 0)
				hdr = hdr ^ PREV_BIT;
			send(mk_write(at, hdr));
			prev_busy = busy;
			at += bsz / 4;
		end
		if (kind == 1)
			send(mk_write(at, ((HEAP_WORDS - at) * 4) | (prev_busy ? PREV_BIT : 32'd0)));
		else
			send(mk_write(at, END_MARK));
	endtask

	task automatic random_op();
		int pick, req;
		int unsigned idx;
		req_t r;
		r.op = OP_NOP;
		r.request_bytes = 16'($urandom);
		r.word_index = 10'($urandom);
		r.write_word = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			case ($urandom_range(0, 3))
				0: req = $urandom_range(1, 128);
				1: req = BLOCK_SIZES[$urandom_range(0, 6)] - 4 - $urandom_range(0, 7);
				2: req = $urandom_range(0, 65535);
				default: req = $urandom_range(0, 600);
			endcase
			if (req < 0)
				req = 1;
			if (!sb.walk_is_safe(req))
				return;
			r.op = OP_ALLOC;
			r.request_bytes = 16'(req);
		end else if (pick < 82) begin
			idx = $urandom_range(0, HEAP_WORDS - 1);
			repeat (16) begin
				if (!sb.written[idx])
					idx = $urandom_range(0, HEAP_WORDS - 1);
			end
			if (!sb.written[idx])
				idx = 0;
			r.op = OP_READ;
			r.word_index = 10'(idx);
		end else if (pick < 96) begin
			r.op = OP_WRITE;
		end
		send(r);
	endtask

	task automatic run_phase(input int unsigned count);
		int unsigned stop;
		stop = sent + count;
		while (sent < stop) begin
			build_heap();
			repeat ($urandom_range(15, 40))
				random_op();
		end
	endtask

	initial begin
		req_t r;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send(mk_write(0, 32'h12));
		send(mk_write(4, 32'h19));
		send(mk_write(10, 32'h32));
		send(mk_write(22, 32'h18));
		send(mk_write(28, END_MARK));
		send(mk_read(0));
		send(mk_alloc(0));
		send(mk_alloc(12));
		send(mk_alloc(20));
		send(mk_alloc(1));
		send(mk_alloc(16'hFFFF));
		send(mk_read(4));
		send(mk_read(10));
		send(mk_read(12));
		send(mk_write(0, 32'h1000));
		send(mk_alloc(8));
		send(mk_alloc(4092));
		send(mk_read(0));
		send(mk_write(0, PREV_BIT));
		send(mk_alloc(8));
		send(mk_write(1023, 32'hFFFF_FFFF));
		send(mk_read(1023));
		r = '1;
		r.op = OP_NOP;
		send(r);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = PHASE_IDLE[ph];
			stall_pct = PHASE_STALL[ph];
			if (ph == 0)
				holds_asked++;
			run_phase(200);
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
